[rtl/aajct_pkg.sv]
package aajct_pkg;

  // configuration register indexes
  localparam logic CFG_FRAME_PERIOD = 1'b0;
  localparam logic CFG_BURST_THR    = 1'b1;

  // configuration reset values
  localparam logic [15:0] FRAME_PERIOD_RST = 16'd10000;
  localparam logic [19:0] BURST_THR_RST    = 20'd8000;

  // tracking loop constants
  localparam logic [31:0]        SLOW_ERR_GATE = 32'd4000;
  localparam logic signed [31:0] SLOW_JIT_GATE = 32'sd5000;
  localparam logic [4:0]         JIT_SHIFT     = 5'd3;
  localparam logic [4:0]         SLOW_SHIFT    = 5'd7;
  localparam logic [4:0]         FAST_SHIFT    = 5'd4;
  localparam logic [31:0]        SLOW_CLAMP    = 32'd300;
  localparam logic [31:0]        FAST_CLAMP    = 32'd2000;

  // input beat
  typedef struct packed {
    logic [31:0]        arrival_time_us;
    logic [31:0]        capture_time_us;
    logic signed [31:0] playout_error_us;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [30:0]        jitter_us;
    logic signed [31:0] clock_offset_out;
    logic signed [31:0] capture_offset_out;
    logic               burst_detected;
  } out_beat_t;

  // pre-processed packet handed from front end to update core
  typedef struct packed {
    logic        first;
    logic [31:0] dev;
    logic        burst;
    logic [31:0] raw;
    logic        err_small;
  } item_t;

endpackage

[rtl/aajct_in_if.sv]
interface aajct_in_if
  import aajct_pkg::*;
;
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/aajct_out_if.sv]
interface aajct_out_if
  import aajct_pkg::*;
;
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/aajct_front.sv]
module aajct_front
  import aajct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [19:0] cfg_data,
  aajct_in_if.sink   in_ch,
  input  logic       take,
  output logic       held,
  output item_t      item
);

  logic [15:0] frame_period;
  logic [19:0] burst_thr;
  logic [31:0] last_arrival;
  logic        seen;
  logic        accept;
  logic [31:0] diff;
  logic [31:0] dev;
  logic [31:0] perr_mag;
  item_t       item_next;

  assign in_ch.ready = !held || take;
  assign accept      = in_ch.valid && in_ch.ready;

  // interarrival deviation, burst test and playout error gate
  always_comb begin
    diff     = in_ch.data.arrival_time_us - last_arrival - {16'd0, frame_period};
    dev      = diff[31] ? (32'd0 - diff) : diff;
    perr_mag = in_ch.data.playout_error_us[31] ?
               (32'd0 - in_ch.data.playout_error_us) : in_ch.data.playout_error_us;
    item_next.first     = !seen;
    item_next.dev       = dev;
    item_next.burst     = seen && (dev >= {12'd0, burst_thr});
    item_next.raw       = in_ch.data.arrival_time_us - in_ch.data.capture_time_us;
    item_next.err_small = perr_mag < SLOW_ERR_GATE;
  end

  // config registers and input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period <= FRAME_PERIOD_RST;
      burst_thr    <= BURST_THR_RST;
      held         <= 1'b0;
      seen         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_PERIOD: frame_period <= cfg_data[15:0];
          CFG_BURST_THR:    burst_thr    <= cfg_data;
          default:          ;
        endcase
      end
      if (accept) begin
        held <= 1'b1;
        seen <= 1'b1;
      end else if (take) begin
        held <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item         <= item_next;
      last_arrival <= in_ch.data.arrival_time_us;
    end
  end

endmodule

[rtl/aajct_core.sv]
module aajct_core
  import aajct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        held,
  input  item_t       item,
  output logic        take,
  aajct_out_if.source out_ch
);

  logic [31:0] jitter;
  logic [31:0] slow_offset;
  logic [31:0] fast_offset;
  logic [31:0] jitter_next;
  logic [31:0] slow_offset_next;
  logic [31:0] fast_offset_next;
  logic        slow_open;
  logic        out_valid;
  out_beat_t   out_data;

  // signed divide by a power of two, truncating toward zero
  function automatic logic [31:0] trunc_shift(input logic [31:0] d, input logic [4:0] sh);
    logic [31:0] bias;
    bias = d[31] ? ((32'd1 << sh) - 32'd1) : 32'd0;
    return 32'($signed(d + bias) >>> sh);
  endfunction

  // truncating divide then clamp to +-lim
  function automatic logic [31:0] sat_shift(input logic [31:0] d, input logic [4:0] sh,
                                            input logic [31:0] lim);
    logic signed [31:0] q;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    q  = $signed(trunc_shift(d, sh));
    hi = $signed(lim);
    lo = -hi;
    if (q > hi) begin
      q = hi;
    end else if (q < lo) begin
      q = lo;
    end
    return 32'(q);
  endfunction

  assign take = held && (!out_valid || out_ch.ready);

  // jitter average and both offset loops
  always_comb begin
    if (item.first) begin
      jitter_next = jitter;
    end else if (jitter == 32'd0) begin
      jitter_next = item.dev;
    end else begin
      jitter_next = jitter + trunc_shift(item.dev - jitter, JIT_SHIFT);
    end
    slow_open = item.err_small && ($signed(jitter_next) < SLOW_JIT_GATE);
    if (item.first) begin
      slow_offset_next = item.raw;
      fast_offset_next = item.raw;
    end else begin
      slow_offset_next = slow_open ?
        slow_offset + sat_shift(item.raw - slow_offset, SLOW_SHIFT, SLOW_CLAMP) : slow_offset;
      fast_offset_next = fast_offset +
        sat_shift(item.raw - fast_offset, FAST_SHIFT, FAST_CLAMP);
    end
  end

  // tracking state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      jitter      <= 32'd0;
      slow_offset <= 32'd0;
      fast_offset <= 32'd0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        jitter      <= jitter_next;
        slow_offset <= slow_offset_next;
        fast_offset <= fast_offset_next;
        out_valid   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.jitter_us          <= jitter_next[30:0];
      out_data.clock_offset_out   <= $signed(slow_offset_next);
      out_data.capture_offset_out <= $signed(fast_offset_next);
      out_data.burst_detected     <= item.burst;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule

[rtl/audio_arrival_jitter_clock_tracker.sv]
// Audio packet arrival jitter and clock offset tracker.
// in_ch carries one beat per received packet: local arrival time, sender
// capture time and the current playout error. out_ch returns one beat per
// packet: smoothed jitter, slow and fast clock offset estimates and a burst
// flag. Both channels are valid/ready; a beat moves when both are high.
// The configuration port writes frame period (index 0) and burst threshold
// (index 1) on any cycle with cfg_we high; write them only while idle.
// An input beat passes through the input register (deviation, raw offset
// and error gate formed there), then the update core, which advances the
// jitter and offset state and loads the result register. Throughput is
// one packet per cycle while out_ch does not stall; the state update is a
// loop through the core's state registers, which sets that rate.
// When out_ch stalls, the result register holds and the input register
// keeps one more packet; in_ch.ready drops only when both are full.
// Synchronous reset empties both stages, restores the config defaults and
// clears the tracking state, so the next packet seeds both offsets.
module audio_arrival_jitter_clock_tracker
  import aajct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  aajct_in_if.sink    in_ch,
  aajct_out_if.source out_ch
);

  logic  held;
  logic  take;
  item_t item;

  aajct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .take      (take),
    .held      (held),
    .item      (item)
  );

  aajct_core u_core (
    .clk    (clk),
    .rst    (rst),
    .held   (held),
    .item   (item),
    .take   (take),
    .out_ch (out_ch)
  );

  // the first packet never reports a burst
  a_first_no_burst : assert property (@(posedge clk) disable iff (rst)
    held && item.first |-> !item.burst)
    else $error("burst flagged on first packet");

  // seeding sets both offsets to the same value
  a_seed_equal : assert property (@(posedge clk) disable iff (rst)
    take && item.first |=> out_ch.valid &&
      (out_ch.data.clock_offset_out == out_ch.data.capture_offset_out))
    else $error("offsets differ after seeding");

  // every core update presents a result beat
  a_take_result : assert property (@(posedge clk) disable iff (rst)
    take |=> out_ch.valid)
    else $error("update without result");

  // backpressure only when the input stage is occupied
  a_ready_held : assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> held && out_ch.valid && !out_ch.ready)
    else $error("input stalled without cause");

endmodule
